// ----- rtl/bas_pkg.sv -----
// ----------------------------------------------------------------------------
// bas_pkg
// Shared types, constants and state codes of the bond active stress
// accumulator.
// ----------------------------------------------------------------------------
package bas_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int SCALE_FRAC        = 16;
   localparam int ROOT_W            = 33;   // floor sqrt of a 66-bit radicand
   localparam int RAD_W             = 66;
   localparam int NUM_W             = 96;   // 32 x 64 product
   localparam int QUO_W             = 64;
   localparam int CSR_IDX_W         = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_FORCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_SCALE = 2'd1;

   localparam logic [31:0] SCALE_RESET = 32'h0001_0000;

   typedef struct packed {
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic               a_local;
      logic               b_local;
      logic               last_bond;
   } req_type;

   typedef struct packed {
      logic signed [63:0] stress_xx;
      logic signed [63:0] stress_xy;
      logic signed [63:0] stress_yx;
      logic signed [63:0] stress_yy;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PREP,
      ST_MXX,
      ST_MYY,
      ST_MXY,
      ST_CAPXY,
      ST_SQRT,
      ST_FLO,
      ST_FHI,
      ST_NUM,
      ST_DIV,
      ST_ACC,
      ST_ACC3,
      ST_LAST,
      ST_OABS,
      ST_OLO,
      ST_OHI,
      ST_OCMB,
      ST_OFIN,
      ST_EMIT
   } state_type;

endpackage

// ----- rtl/bond_active_stress_accumulator_top.sv -----
// ----------------------------------------------------------------------------
// bond_active_stress_accumulator_top
// Accumulates the active stress of a stream of 2D bonds and emits the four
// scaled tensor sums on the last bond of a list.
//
//   channel  dir  handshake           payload
//   req      in   req_valid/req_stall req_type  (one bond)
//   rsp      out  rsp_valid/rsp_stall rsp_type  (four stress sums)
//   csr      in   csr_valid/csr_ready csr_index, csr_data
//
// A counting bond runs one 33-step square root and three 96-step divisions
// on the one-bit-per-cycle divider, plus the shared multiplier steps. A
// ghost or zero-length bond skips them all. The last bond adds the output
// scaling of the four sums. req_stall is high while a bond is in work; a
// pending response waits in its own register under rsp_stall.
// Reset is synchronous, clears the sums and loads both registers' defaults.
// ----------------------------------------------------------------------------
module bond_active_stress_accumulator_top import bas_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   localparam int DEN_W = ROOT_W + FRAC_BITS;
   localparam int SH    = FRAC_BITS - SCALE_FRAC;
   localparam int SHR   = (SH > 0) ? SH : 0;
   localparam int SHL   = (SH < 0) ? -SH : 0;
   localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
   localparam logic [63:0] S64_MIN = {1'b1, {63{1'b0}}};

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [31:0]        force_ff, force_in;
   logic [31:0]        scale_ff, scale_in;
   logic               dxneg_ff, dxneg_in;
   logic               dyneg_ff, dyneg_in;
   logic [31:0]        mx_ff, mx_in;
   logic [31:0]        my_ff, my_in;
   logic [31:0]        fm_ff, fm_in;
   logic               fneg_ff, fneg_in;
   logic [63:0]        pxx_ff, pxx_in;
   logic [63:0]        pyy_ff, pyy_in;
   logic [63:0]        pxy_ff, pxy_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [63:0]        lo_ff, lo_in;
   logic [63:0]        term_ff, term_in;
   logic [1:0]         idx_ff, idx_in;
   logic [63:0]        sums_ff [4];
   logic [63:0]        sums_in [4];
   logic [63:0]        mag_ff, mag_in;
   logic               sneg_ff, sneg_in;
   logic [NUM_W-1:0]   prod_ff, prod_in;
   logic [63:0]        res_ff [4];
   logic [63:0]        res_in [4];
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [31:0]        mul_a, mul_b;
   logic [63:0]        mul_p;
   logic               sq_start, sq_done;
   logic [RAD_W-1:0]   sq_rad;
   logic [ROOT_W-1:0]  sq_root;
   logic               dv_start, dv_done;
   logic [NUM_W-1:0]   dv_num;
   logic [QUO_W-1:0]   dv_quot;

   // datapath helpers
   logic               a_first, is_local;
   logic signed [32:0] dx, dy;
   logic [63:0]        pmag;
   logic               tneg;
   logic [1:0]         rd_idx;
   logic [63:0]        acc_s, acc_v, acc_sum, acc_res;
   logic               acc_ovf;
   logic [127:0]       wide, shifted, lim;
   logic [63:0]        magsat;

   bas_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   bas_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_rad),
      .root     (sq_root),
      .done     (sq_done)
   );

   bas_div #(.DEN_W(DEN_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .numer (dv_num),
      .denom (den_ff),
      .quot  (dv_quot),
      .done  (dv_done)
   );

   always_comb begin
      a_first  = req_ff.a_y < req_ff.b_y;
      is_local = a_first ? req_ff.a_local : req_ff.b_local;
      dx = a_first ? ({req_ff.b_x[31], req_ff.b_x} - {req_ff.a_x[31], req_ff.a_x})
                   : ({req_ff.a_x[31], req_ff.a_x} - {req_ff.b_x[31], req_ff.b_x});
      dy = a_first ? ({req_ff.b_y[31], req_ff.b_y} - {req_ff.a_y[31], req_ff.a_y})
                   : ({req_ff.a_y[31], req_ff.a_y} - {req_ff.b_y[31], req_ff.b_y});

      case (idx_ff)
         2'd0:    begin pmag = pxy_ff; tneg = fneg_ff ^ dxneg_ff ^ dyneg_ff; end
         2'd1:    begin pmag = pyy_ff; tneg = fneg_ff;  end
         default: begin pmag = pxx_ff; tneg = !fneg_ff; end
      endcase

      rd_idx  = (state_ff == ST_ACC3) ? 2'd3 : idx_ff;
      acc_s   = sums_ff[rd_idx];
      acc_v   = (state_ff == ST_ACC3) ? (64'd0 - term_ff) : term_ff;
      acc_sum = acc_s + acc_v;
      acc_ovf = (acc_s[63] == acc_v[63]) && (acc_sum[63] != acc_s[63]);
      acc_res = acc_ovf ? (acc_v[63] ? S64_MIN : S64_MAX) : acc_sum;

      // output scaling: shift by FRAC_BITS-16, then saturate the magnitude
      wide    = {32'd0, prod_ff};
      shifted = (wide >> SHR) << SHL;
      lim     = sneg_ff ? {64'd0, S64_MIN} : {64'd0, S64_MAX};
      magsat  = (shifted > lim) ? lim[63:0] : shifted[63:0];

      sq_rad = {2'b00, pxx_ff} + {2'b00, pyy_ff};
      dv_num = {mul_p, 32'd0} + {32'd0, lo_ff};
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      force_in     = force_ff;
      scale_in     = scale_ff;
      dxneg_in     = dxneg_ff;
      dyneg_in     = dyneg_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      fm_in        = fm_ff;
      fneg_in      = fneg_ff;
      pxx_in       = pxx_ff;
      pyy_in       = pyy_ff;
      pxy_in       = pxy_ff;
      den_in       = den_ff;
      lo_in        = lo_ff;
      term_in      = term_ff;
      idx_in       = idx_ff;
      sums_in      = sums_ff;
      mag_in       = mag_ff;
      sneg_in      = sneg_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      mul_a        = '0;
      mul_b        = '0;
      sq_start     = 1'b0;
      dv_start     = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         case (csr_index)
            CSR_ACTIVE_FORCE: force_in = csr_data;
            CSR_OUTPUT_SCALE: scale_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            dxneg_in = dx[32];
            dyneg_in = dy[32];
            mx_in    = dx[32] ? 32'(-dx) : dx[31:0];
            my_in    = dy[32] ? 32'(-dy) : dy[31:0];
            fneg_in  = force_ff[31];
            fm_in    = force_ff[31] ? (32'd0 - force_ff) : force_ff;
            idx_in   = 2'd0;
            if (is_local && (dx != '0 || dy != '0)) begin
               state_in = ST_MXX;
            end else begin
               state_in = ST_LAST;
            end
         end
         ST_MXX: begin
            mul_a    = mx_ff;
            mul_b    = mx_ff;
            state_in = ST_MYY;
         end
         ST_MYY: begin
            mul_a    = my_ff;
            mul_b    = my_ff;
            pxx_in   = mul_p;
            state_in = ST_MXY;
         end
         ST_MXY: begin
            mul_a    = mx_ff;
            mul_b    = my_ff;
            pyy_in   = mul_p;
            state_in = ST_CAPXY;
         end
         ST_CAPXY: begin
            pxy_in   = mul_p;
            sq_start = 1'b1;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (sq_done) begin
               den_in   = DEN_W'(sq_root) << FRAC_BITS;
               state_in = ST_FLO;
            end
         end
         ST_FLO: begin
            mul_a    = fm_ff;
            mul_b    = pmag[31:0];
            state_in = ST_FHI;
         end
         ST_FHI: begin
            mul_a    = fm_ff;
            mul_b    = pmag[63:32];
            lo_in    = mul_p;
            state_in = ST_NUM;
         end
         ST_NUM: begin
            dv_start = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (dv_done) begin
               term_in  = tneg ? (64'd0 - dv_quot) : dv_quot;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            sums_in[rd_idx] = acc_res;
            if (idx_ff == 2'd0) begin
               state_in = ST_ACC3;
            end else if (idx_ff == 2'd2) begin
               state_in = ST_LAST;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_FLO;
            end
         end
         ST_ACC3: begin
            // the fourth sum takes the negated cross term
            sums_in[rd_idx] = acc_res;
            idx_in          = 2'd1;
            state_in        = ST_FLO;
         end
         ST_LAST: begin
            idx_in   = 2'd0;
            state_in = req_ff.last_bond ? ST_OABS : ST_IDLE;
         end
         ST_OABS: begin
            sneg_in  = acc_s[63];
            mag_in   = acc_s[63] ? (64'd0 - acc_s) : acc_s;
            state_in = ST_OLO;
         end
         ST_OLO: begin
            mul_a    = mag_ff[31:0];
            mul_b    = scale_ff;
            state_in = ST_OHI;
         end
         ST_OHI: begin
            mul_a    = mag_ff[63:32];
            mul_b    = scale_ff;
            lo_in    = mul_p;
            state_in = ST_OCMB;
         end
         ST_OCMB: begin
            prod_in  = dv_num;
            state_in = ST_OFIN;
         end
         ST_OFIN: begin
            res_in[idx_ff]  = sneg_ff ? (64'd0 - magsat) : magsat;
            sums_in[idx_ff] = '0;
            if (idx_ff == 2'd3) begin
               state_in = ST_EMIT;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_OABS;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.stress_xx = res_ff[0];
               rsp_in.stress_xy = res_ff[1];
               rsp_in.stress_yx = res_ff[2];
               rsp_in.stress_yy = res_ff[3];
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         force_ff     <= '0;
         scale_ff     <= SCALE_RESET;
         sums_ff      <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         force_ff     <= force_in;
         scale_ff     <= scale_in;
         sums_ff      <= sums_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      dxneg_ff <= dxneg_in;
      dyneg_ff <= dyneg_in;
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      fm_ff    <= fm_in;
      fneg_ff  <= fneg_in;
      pxx_ff   <= pxx_in;
      pyy_ff   <= pyy_in;
      pxy_ff   <= pxy_in;
      den_ff   <= den_in;
      lo_ff    <= lo_in;
      term_ff  <= term_in;
      idx_ff   <= idx_in;
      mag_ff   <= mag_in;
      sneg_ff  <= sneg_in;
      prod_ff  <= prod_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

   a_accept_prep: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_PREP))
      else $error("accepted bond did not start preparation");

   a_sqrt_done: assert property (@(posedge clock) disable iff (reset)
      sq_done |-> (state_ff == ST_SQRT))
      else $error("square root finished outside its wait state");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      dv_done |-> (state_ff == ST_DIV))
      else $error("division finished outside its wait state");

   a_sums_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (sums_ff[0] == '0 && sums_ff[1] == '0 &&
                                 sums_ff[2] == '0 && sums_ff[3] == '0))
      else $error("sums not cleared before emitting");

   a_emit_next: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OFIN && idx_ff == 2'd3) |=> (state_ff == ST_EMIT))
      else $error("output scaling did not end in emit");

endmodule

// ----- rtl/bas_mul.sv -----
// ----------------------------------------------------------------------------
// bas_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module bas_mul import bas_pkg::*; (
   input  logic        clock,
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [63:0] mul_p
);

   logic [63:0] p_ff;
   logic [63:0] p_in;

   assign p_in  = mul_a * mul_b;
   assign mul_p = p_ff;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

endmodule

// ----- rtl/bas_sqrt.sv -----
// ----------------------------------------------------------------------------
// bas_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module bas_sqrt import bas_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic [ROOT_W-1:0] root,
   output logic              done
);

   localparam int REM_W = ROOT_W + 3;
   localparam int CNT_W = $clog2(ROOT_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [REM_W-1:0]  rem_ff, rem_in;

   logic [REM_W+1:0]  trial;
   logic [REM_W+1:0]  sub;
   logic              ge;

   always_comb begin
      trial   = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      sub     = (REM_W+2)'({root_ff, 2'b01});
      ge      = trial >= sub;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         root_in = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
         root_in = {root_ff[ROOT_W-2:0], ge};
         rem_in  = ge ? REM_W'(trial - sub) : REM_W'(trial);
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

// ----- rtl/bas_div.sv -----
// ----------------------------------------------------------------------------
// bas_div
// Restoring divider, one quotient bit per cycle. Keeps the low quotient bits.
// ----------------------------------------------------------------------------
module bas_div import bas_pkg::*; #(
   parameter int DEN_W = ROOT_W + FRAC_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic [QUO_W-1:0] quot,
   output logic             done
);

   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;

   logic [DEN_W:0]   rem_sh;
   logic             ge;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         rem_in = ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : DEN_W'(rem_sh);
         quo_in = {quo_ff[QUO_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quot = quo_ff;
   assign done = done_ff;

endmodule
